/* sv/ccp_pkg.sv */
// Package for the color token parser: payload structs, phase codes, name table.
// No dependencies.
package ccp_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_WS, PH_HEX, PH_HEX_DONE, PH_NAME, PH_NAME_DONE, PH_RGB_SEP, PH_RGB_NUM,
      PH_RGBA_SEP, PH_RGBA_NUM, PH_A_SEP, PH_A_WHOLE, PH_A_FRAC, PH_OK, PH_FAIL
   } phase_type;

   localparam int TABLE_NAMES = 29;
   localparam int FIXED_ENTRIES = 3;
   localparam int MAX_ENTRIES = FIXED_ENTRIES + TABLE_NAMES;

   typedef struct packed {
      logic [95:0] text;   // up to 12 characters, first character in the top byte
      logic [3:0]  len;
      logic [7:0]  r, g, b, a;
   } entry_type;

   function automatic entry_type entry(input int i);
      entry_type e;
      case (i)
         0:  e = '{"rgba(", 4'd5, 8'd0, 8'd0, 8'd0, 8'd0};
         1:  e = '{"rgb(", 4'd4, 8'd0, 8'd0, 8'd0, 8'd0};
         2:  e = '{"transparent", 4'd11, 8'd0, 8'd0, 8'd0, 8'd0};
         3:  e = '{"black", 4'd5, 8'd0, 8'd0, 8'd0, 8'd255};
         4:  e = '{"white", 4'd5, 8'd255, 8'd255, 8'd255, 8'd255};
         5:  e = '{"red", 4'd3, 8'd255, 8'd0, 8'd0, 8'd255};
         6:  e = '{"green", 4'd5, 8'd0, 8'd128, 8'd0, 8'd255};
         7:  e = '{"lime", 4'd4, 8'd0, 8'd255, 8'd0, 8'd255};
         8:  e = '{"blue", 4'd4, 8'd0, 8'd0, 8'd255, 8'd255};
         9:  e = '{"yellow", 4'd6, 8'd255, 8'd255, 8'd0, 8'd255};
         10: e = '{"cyan", 4'd4, 8'd0, 8'd255, 8'd255, 8'd255};
         11: e = '{"aqua", 4'd4, 8'd0, 8'd255, 8'd255, 8'd255};
         12: e = '{"magenta", 4'd7, 8'd255, 8'd0, 8'd255, 8'd255};
         13: e = '{"fuchsia", 4'd7, 8'd255, 8'd0, 8'd255, 8'd255};
         14: e = '{"gray", 4'd4, 8'd128, 8'd128, 8'd128, 8'd255};
         15: e = '{"grey", 4'd4, 8'd128, 8'd128, 8'd128, 8'd255};
         16: e = '{"silver", 4'd6, 8'd192, 8'd192, 8'd192, 8'd255};
         17: e = '{"maroon", 4'd6, 8'd128, 8'd0, 8'd0, 8'd255};
         18: e = '{"olive", 4'd5, 8'd128, 8'd128, 8'd0, 8'd255};
         19: e = '{"navy", 4'd4, 8'd0, 8'd0, 8'd128, 8'd255};
         20: e = '{"teal", 4'd4, 8'd0, 8'd128, 8'd128, 8'd255};
         21: e = '{"purple", 4'd6, 8'd128, 8'd0, 8'd128, 8'd255};
         22: e = '{"orange", 4'd6, 8'd255, 8'd165, 8'd0, 8'd255};
         23: e = '{"pink", 4'd4, 8'd255, 8'd192, 8'd203, 8'd255};
         24: e = '{"brown", 4'd5, 8'd165, 8'd42, 8'd42, 8'd255};
         25: e = '{"gold", 4'd4, 8'd255, 8'd215, 8'd0, 8'd255};
         26: e = '{"darkgray", 4'd8, 8'd169, 8'd169, 8'd169, 8'd255};
         27: e = '{"darkgrey", 4'd8, 8'd169, 8'd169, 8'd169, 8'd255};
         28: e = '{"lightgray", 4'd9, 8'd211, 8'd211, 8'd211, 8'd255};
         29: e = '{"lightgrey", 4'd9, 8'd211, 8'd211, 8'd211, 8'd255};
         30: e = '{"dodgerblue", 4'd10, 8'd30, 8'd144, 8'd255, 8'd255};
         31: e = '{"steelblue", 4'd9, 8'd70, 8'd130, 8'd180, 8'd255};
         default: e = '0;
      endcase
      // left-align text so character 0 sits in the top byte
      e.text = e.text << (8 * (12 - int'(e.len)));
      return e;
   endfunction

   function automatic logic [7:0] entry_char(input int i, input logic [3:0] pos);
      entry_type e;
      logic [95:0] t;
      e = entry(i);
      t = e.text << (8 * int'(pos));
      return t[95:88];
   endfunction

endpackage

/* sv/ccp_name_match.sv */
// Name matcher: narrows the live candidate set by one character.
// Depends on ccp_pkg for the literal table.
module ccp_name_match #(
   parameter int ENTRY_LIMIT = 32
) (
   input  logic [7:0]             lower_char,
   input  logic [3:0]             char_pos,
   input  logic [ENTRY_LIMIT-1:0] live_in,
   output logic [ENTRY_LIMIT-1:0] live_out
);

   // Drop every literal whose character at this place differs
   always_comb begin
      ccp_pkg::entry_type ent;
      ent = '0;
      for (int i = 0; i < ENTRY_LIMIT; i++) begin
         ent = ccp_pkg::entry(i);
         live_out[i] = live_in[i] && (char_pos < ent.len)
                       && (lower_char == ccp_pkg::entry_char(i, char_pos));
      end
   end

endmodule

/* sv/css_color_token_parser.sv */
// Top level of the streaming color token parser.
// Depends on ccp_pkg and ccp_name_match.
//
//  channel | dir | payload  | handshake
//  req     | in  | req_type | req_valid / req_stall
//  rsp     | out | rsp_type | rsp_valid / rsp_stall
//
// One character per cycle unless req is stalled; a result appears the cycle after
// its last character. The parse state updates in one combinational pass between
// the character and the parser registers; the result register sits behind it.
// Synchronous reset clears the parser state and the result valid.
// A stall on rsp holds the result; req is stalled only while a result waits.
module css_color_token_parser #(
   parameter int NAME_COUNT = 29
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ccp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ccp_pkg::rsp_type rsp_data
);

   localparam int NAMES_USED = (NAME_COUNT < ccp_pkg::TABLE_NAMES) ? NAME_COUNT
                                                                   : ccp_pkg::TABLE_NAMES;
   localparam int ENTRY_LIMIT = ccp_pkg::FIXED_ENTRIES + NAMES_USED;

   ccp_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic [ENTRY_LIMIT-1:0] cand_ff, cand_in, cand_match;
   logic [2:0]             hcnt_ff, hcnt_in;
   logic [23:0]            hex_ff, hex_in;
   logic [8:0]             ch_ff [3];
   logic [8:0]             ch_in [3];
   logic [1:0]             comp_ff, comp_in;
   logic                   awn_ff, awn_in;
   logic [9:0]             ath_ff, ath_in;
   logic [1:0]             fcnt_ff, fcnt_in;
   logic                   rsp_valid_ff;
   ccp_pkg::rsp_type       rsp_ff, rsp_in;

   logic [7:0] c, lc;
   logic       accept, is_space, is_sep, is_digit;
   logic [3:0] dig;
   logic [4:0] nib;
   logic       name_step;
   logic [12:0] mul;
   logic [9:0]  a1000;
   logic [36:0] aprod;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign c        = req_data.char_code;
   assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   assign is_space = c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd12;
   assign is_sep   = is_space || c == ",";
   assign is_digit = c >= "0" && c <= "9";
   assign dig      = 4'(c - "0");

   // Hex nibble value, 16 when not a hex digit
   always_comb begin
      if (is_digit) nib = {1'b0, dig};
      else if (lc >= "a" && lc <= "f") nib = 5'(lc - "a" + 8'd10);
      else nib = 5'd16;
   end

   ccp_name_match #(.ENTRY_LIMIT(ENTRY_LIMIT)) u_match (
      .lower_char(lc),
      .char_pos  (pos_ff),
      .live_in   (cand_ff),
      .live_out  (cand_match)
   );

   // Advance the parse state by one character; last or a zero byte closes the token
   always_comb begin
      logic [1:0] k;
      logic       ended;
      logic [7:0] r, g, b, a;
      logic       ok;
      ccp_pkg::entry_type ent;
      k = comp_ff;
      ent = '0;
      phase_in = phase_ff; pos_in = pos_ff; cand_in = cand_ff;
      hcnt_in = hcnt_ff; hex_in = hex_ff; ch_in = ch_ff; comp_in = comp_ff;
      awn_in = awn_ff; ath_in = ath_ff; fcnt_in = fcnt_ff;
      name_step = 1'b0;
      mul = '0;
      ended = (c == 8'd0) || req_data.last;
      if (c != 8'd0) begin
         case (phase_ff)
            ccp_pkg::PH_WS: begin
               if (!is_space) begin
                  if (c == "#") phase_in = ccp_pkg::PH_HEX;
                  else begin
                     phase_in = ccp_pkg::PH_NAME;
                     name_step = 1'b1;
                  end
               end
            end
            ccp_pkg::PH_HEX: begin
               if (nib[4]) phase_in = ccp_pkg::PH_HEX_DONE;
               else begin
                  if (hcnt_ff < 3'd6) hex_in = {hex_ff[19:0], nib[3:0]};
                  if (hcnt_ff < 3'd7) hcnt_in = hcnt_ff + 3'd1;
               end
            end
            ccp_pkg::PH_NAME: name_step = 1'b1;
            ccp_pkg::PH_RGB_SEP, ccp_pkg::PH_RGBA_SEP: begin
               if (!is_sep) begin
                  if (is_digit && k < 2'd3) begin
                     ch_in[k] = {5'd0, dig};
                     phase_in = (phase_ff == ccp_pkg::PH_RGB_SEP) ? ccp_pkg::PH_RGB_NUM
                                                                  : ccp_pkg::PH_RGBA_NUM;
                  end else phase_in = ccp_pkg::PH_FAIL;
               end
            end
            ccp_pkg::PH_RGB_NUM, ccp_pkg::PH_RGBA_NUM: begin
               if (k > 2'd2) phase_in = ccp_pkg::PH_FAIL;
               else if (is_digit) begin
                  mul = 13'(ch_ff[k]) * 13'd10 + 13'(dig);
                  ch_in[k] = (mul > 13'd256) ? 9'd256 : mul[8:0];
               end else if (k < 2'd2) begin
                  comp_in = k + 2'd1;
                  phase_in = (phase_ff == ccp_pkg::PH_RGB_NUM) ? ccp_pkg::PH_RGB_SEP
                                                               : ccp_pkg::PH_RGBA_SEP;
                  if (!is_sep) phase_in = ccp_pkg::PH_FAIL;
               end else if (phase_ff == ccp_pkg::PH_RGB_NUM) begin
                  awn_in = 1'b1;
                  phase_in = ccp_pkg::PH_OK;
               end else begin
                  comp_in = 2'd3;
                  phase_in = ccp_pkg::PH_A_SEP;
                  if (!is_sep) begin
                     if (is_digit) begin
                        phase_in = ccp_pkg::PH_A_WHOLE;
                        if (c != "0") awn_in = 1'b1;
                     end else if (c == ".") phase_in = ccp_pkg::PH_A_FRAC;
                     else phase_in = ccp_pkg::PH_FAIL;
                  end
               end
            end
            ccp_pkg::PH_A_SEP: begin
               if (!is_sep) begin
                  if (is_digit) begin
                     phase_in = ccp_pkg::PH_A_WHOLE;
                     if (c != "0") awn_in = 1'b1;
                  end else if (c == ".") phase_in = ccp_pkg::PH_A_FRAC;
                  else phase_in = ccp_pkg::PH_FAIL;
               end
            end
            ccp_pkg::PH_A_WHOLE: begin
               if (is_digit) begin
                  if (c != "0") awn_in = 1'b1;
               end else if (c == ".") phase_in = ccp_pkg::PH_A_FRAC;
               else phase_in = ccp_pkg::PH_OK;
            end
            ccp_pkg::PH_A_FRAC: begin
               if (is_digit) begin
                  if (fcnt_ff < 2'd3) begin
                     case (fcnt_ff)
                        2'd0:    ath_in = ath_ff + 10'(dig) * 10'd100;
                        2'd1:    ath_in = ath_ff + 10'(dig) * 10'd10;
                        default: ath_in = ath_ff + 10'(dig);
                     endcase
                     fcnt_in = fcnt_ff + 2'd1;
                  end
               end else phase_in = ccp_pkg::PH_OK;
            end
            default: ;
         endcase
      end
      // Name step: narrow candidates and pick the function forms
      if (name_step) begin
         cand_in = cand_match;
         if (cand_match[0] && pos_ff == 4'd4) phase_in = ccp_pkg::PH_RGBA_SEP;
         else if (cand_match[1] && pos_ff == 4'd3) phase_in = ccp_pkg::PH_RGB_SEP;
         else if (cand_match == '0) phase_in = ccp_pkg::PH_FAIL;
         if (pos_ff < 4'd15) pos_in = pos_ff + 4'd1;
      end
      // End of token closes the open phase
      if (ended) begin
         case (phase_in)
            ccp_pkg::PH_HEX:  phase_in = ccp_pkg::PH_HEX_DONE;
            ccp_pkg::PH_NAME: phase_in = ccp_pkg::PH_NAME_DONE;
            ccp_pkg::PH_RGB_NUM: begin
               if (comp_in == 2'd2) begin
                  awn_in = 1'b1;
                  phase_in = ccp_pkg::PH_OK;
               end else phase_in = ccp_pkg::PH_FAIL;
            end
            ccp_pkg::PH_A_WHOLE, ccp_pkg::PH_A_FRAC: phase_in = ccp_pkg::PH_OK;
            ccp_pkg::PH_HEX_DONE, ccp_pkg::PH_NAME_DONE, ccp_pkg::PH_OK,
            ccp_pkg::PH_FAIL: ;
            default: phase_in = ccp_pkg::PH_FAIL;
         endcase
      end
      // Build the result
      ok = 1'b0; r = '0; g = '0; b = '0; a = '0;
      a1000 = awn_in ? 10'd1000 : ath_in;
      // Round thousandths to 0..255: scale by 255, add half, divide by 1000 through
      // a reciprocal multiply (2^28 / 1000, rounded up) folded into the constants
      aprod = 37'(a1000) * 37'd68451180 + 37'd134218000;
      case (phase_in)
         ccp_pkg::PH_HEX_DONE: begin
            if (hcnt_in == 3'd3) begin
               ok = 1'b1; a = 8'd255;
               r = {hex_in[11:8], hex_in[11:8]};
               g = {hex_in[7:4], hex_in[7:4]};
               b = {hex_in[3:0], hex_in[3:0]};
            end else if (hcnt_in == 3'd6) begin
               ok = 1'b1; a = 8'd255;
               r = hex_in[23:16]; g = hex_in[15:8]; b = hex_in[7:0];
            end
         end
         ccp_pkg::PH_NAME_DONE: begin
            for (int i = ENTRY_LIMIT - 1; i >= 2; i--) begin
               ent = ccp_pkg::entry(i);
               if (cand_in[i] && ent.len == pos_in) begin
                  ok = 1'b1;
                  r = ent.r; g = ent.g;
                  b = ent.b; a = ent.a;
               end
            end
         end
         ccp_pkg::PH_OK: begin
            ok = 1'b1;
            r = ch_in[0][8] ? 8'd255 : ch_in[0][7:0];
            g = ch_in[1][8] ? 8'd255 : ch_in[1][7:0];
            b = ch_in[2][8] ? 8'd255 : ch_in[2][7:0];
            a = aprod[35:28];
         end
         default: ;
      endcase
      rsp_in = '{ok, r, g, b, a};
   end

   // Hold or advance the parse state; clear it after each result
   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last)) begin
         phase_ff <= ccp_pkg::PH_WS;
         pos_ff   <= '0;
         cand_ff  <= '1;
         hcnt_ff  <= '0;
         hex_ff   <= '0;
         ch_ff    <= '{default: '0};
         comp_ff  <= '0;
         awn_ff   <= 1'b0;
         ath_ff   <= '0;
         fcnt_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         cand_ff  <= cand_in;
         hcnt_ff  <= hcnt_in;
         hex_ff   <= hex_in;
         ch_ff    <= ch_in;
         comp_ff  <= comp_in;
         awn_ff   <= awn_in;
         ath_ff   <= ath_in;
         fcnt_ff  <= fcnt_in;
      end
   end

   // Result register: load on last, drop when taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (accept && req_data.last) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (accept && req_data.last) rsp_ff <= rsp_in;
   end

endmodule

/* tb/sv/ccp_checker.sv */
// Checker for the color token parser: watches both channels, predicts each result
// from the accepted characters and compares field by field. Depends on ccp_pkg.
`timescale 1ns / 1ps
module ccp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ccp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ccp_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);

   localparam int NUM_ENTRIES = ccp_pkg::MAX_ENTRIES;

   // predictor state
   ccp_pkg::phase_type ph;
   logic [3:0]  npos;
   logic [31:0] cand;
   logic [2:0]  hcount;
   logic [23:0] hval;
   logic [8:0]  chan [3];
   logic [1:0]  cidx;
   logic        awhole;
   logic [9:0]  athou;
   logic [1:0]  fcount;

   ccp_pkg::rsp_type colors_due [$];

   function automatic logic is_ws(logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd12;
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   // table kept locally so the prediction does not lean on package helpers
   function automatic string ent_text(int i);
      string t [32] = '{"rgba(", "rgb(", "transparent", "black", "white", "red", "green",
         "lime", "blue", "yellow", "cyan", "aqua", "magenta", "fuchsia", "gray", "grey",
         "silver", "maroon", "olive", "navy", "teal", "purple", "orange", "pink", "brown",
         "gold", "darkgray", "darkgrey", "lightgray", "lightgrey", "dodgerblue",
         "steelblue"};
      return t[i];
   endfunction

   function automatic logic [31:0] ent_rgba(int i);
      logic [31:0] v [32] = '{32'h0, 32'h0, 32'h0, 32'h000000ff, 32'hffffffff,
         32'hff0000ff, 32'h008000ff, 32'h00ff00ff, 32'h0000ffff, 32'hffff00ff,
         32'h00ffffff, 32'h00ffffff, 32'hff00ffff, 32'hff00ffff, 32'h808080ff,
         32'h808080ff, 32'hc0c0c0ff, 32'h800000ff, 32'h808000ff, 32'h000080ff,
         32'h008080ff, 32'h800080ff, 32'hffa500ff, 32'hffc0cbff, 32'ha52a2aff,
         32'hffd700ff, 32'ha9a9a9ff, 32'ha9a9a9ff, 32'hd3d3d3ff, 32'hd3d3d3ff,
         32'h1e90ffff, 32'h4682b4ff};
      return v[i];
   endfunction

   task automatic clear_parse();
      ph = ccp_pkg::PH_WS; npos = 0; cand = '1; hcount = 0; hval = 0;
      chan[0] = 0; chan[1] = 0; chan[2] = 0;
      cidx = 0; awhole = 0; athou = 0; fcount = 0;
   endtask

   task automatic match_name(logic [7:0] c);
      string t;
      logic [7:0] l;
      l = to_lower(c);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         t = ent_text(i);
         if (!(npos < t.len() && l == t[npos])) cand[i] = 1'b0;
      end
      if (cand[0] && npos == 4) ph = ccp_pkg::PH_RGBA_SEP;
      else if (cand[1] && npos == 3) ph = ccp_pkg::PH_RGB_SEP;
      else if (cand == 0) ph = ccp_pkg::PH_FAIL;
      if (npos < 15) npos++;
   endtask

   task automatic alpha_begin(logic [7:0] c);
      if (is_ws(c) || c == ",") return;
      if (is_dig(c)) begin
         ph = ccp_pkg::PH_A_WHOLE;
         if (c != "0") awhole = 1;
      end else if (c == ".") ph = ccp_pkg::PH_A_FRAC;
      else ph = ccp_pkg::PH_FAIL;
   endtask

   task automatic consume_char(logic [7:0] c);
      int n;
      int k;
      k = cidx;
      case (ph)
         ccp_pkg::PH_WS: begin
            if (is_ws(c)) return;
            if (c == "#") ph = ccp_pkg::PH_HEX;
            else begin
               ph = ccp_pkg::PH_NAME;
               match_name(c);
            end
         end
         ccp_pkg::PH_HEX: begin
            if (is_dig(c)) n = c - "0";
            else if (to_lower(c) >= "a" && to_lower(c) <= "f") n = to_lower(c) - "a" + 10;
            else n = 16;
            if (n > 15) ph = ccp_pkg::PH_HEX_DONE;
            else begin
               if (hcount < 6) hval = {hval[19:0], 4'(n)};
               if (hcount < 7) hcount++;
            end
         end
         ccp_pkg::PH_NAME: match_name(c);
         ccp_pkg::PH_RGB_SEP, ccp_pkg::PH_RGBA_SEP: begin
            if (is_ws(c) || c == ",") return;
            if (is_dig(c) && k < 3) begin
               chan[k] = 9'(c - "0");
               ph = (ph == ccp_pkg::PH_RGB_SEP) ? ccp_pkg::PH_RGB_NUM : ccp_pkg::PH_RGBA_NUM;
            end else ph = ccp_pkg::PH_FAIL;
         end
         ccp_pkg::PH_RGB_NUM, ccp_pkg::PH_RGBA_NUM: begin
            if (k > 2) ph = ccp_pkg::PH_FAIL;
            else if (is_dig(c)) begin
               n = chan[k] * 10 + (c - "0");
               chan[k] = 9'(n > 256 ? 256 : n);
            end else if (k < 2) begin
               cidx = 2'(k + 1);
               ph = (ph == ccp_pkg::PH_RGB_NUM) ? ccp_pkg::PH_RGB_SEP : ccp_pkg::PH_RGBA_SEP;
               if (!(is_ws(c) || c == ",")) ph = ccp_pkg::PH_FAIL;
            end else if (ph == ccp_pkg::PH_RGB_NUM) begin
               awhole = 1;
               ph = ccp_pkg::PH_OK;
            end else begin
               cidx = 2'd3;
               ph = ccp_pkg::PH_A_SEP;
               alpha_begin(c);
            end
         end
         ccp_pkg::PH_A_SEP: alpha_begin(c);
         ccp_pkg::PH_A_WHOLE: begin
            if (is_dig(c)) begin
               if (c != "0") awhole = 1;
            end else if (c == ".") ph = ccp_pkg::PH_A_FRAC;
            else ph = ccp_pkg::PH_OK;
         end
         ccp_pkg::PH_A_FRAC: begin
            if (is_dig(c)) begin
               if (fcount < 3) begin
                  athou = athou + 10'((c - "0") * (fcount == 0 ? 100 : fcount == 1 ? 10 : 1));
                  fcount++;
               end
            end else ph = ccp_pkg::PH_OK;
         end
         default: ;
      endcase
   endtask

   task automatic close_token();
      case (ph)
         ccp_pkg::PH_HEX: ph = ccp_pkg::PH_HEX_DONE;
         ccp_pkg::PH_NAME: ph = ccp_pkg::PH_NAME_DONE;
         ccp_pkg::PH_RGB_NUM: begin
            if (cidx == 2) begin
               awhole = 1;
               ph = ccp_pkg::PH_OK;
            end else ph = ccp_pkg::PH_FAIL;
         end
         ccp_pkg::PH_A_WHOLE, ccp_pkg::PH_A_FRAC: ph = ccp_pkg::PH_OK;
         ccp_pkg::PH_HEX_DONE, ccp_pkg::PH_NAME_DONE, ccp_pkg::PH_OK, ccp_pkg::PH_FAIL: ;
         default: ph = ccp_pkg::PH_FAIL;
      endcase
   endtask

   // advance the parse by one character; push a color at the token end
   task automatic predict_color(ccp_pkg::req_type r);
      ccp_pkg::rsp_type o;
      int a1000;
      logic [31:0] v;
      string t;
      o = '0;
      if (r.char_code == 0) close_token();
      else consume_char(r.char_code);
      if (!r.last) return;
      close_token();
      if (ph == ccp_pkg::PH_HEX_DONE) begin
         if (hcount == 3) begin
            o.ok = 1; o.alpha = 255;
            o.red = hval[11:8] * 8'd17;
            o.green = hval[7:4] * 8'd17;
            o.blue = hval[3:0] * 8'd17;
         end else if (hcount == 6) begin
            o.ok = 1; o.alpha = 255;
            o.red = hval[23:16]; o.green = hval[15:8]; o.blue = hval[7:0];
         end
      end else if (ph == ccp_pkg::PH_NAME_DONE) begin
         for (int i = 2; i < NUM_ENTRIES; i++) begin
            t = ent_text(i);
            if (cand[i] && t.len() == npos) begin
               v = ent_rgba(i);
               o.ok = 1;
               {o.red, o.green, o.blue, o.alpha} = v;
               break;
            end
         end
      end else if (ph == ccp_pkg::PH_OK) begin
         a1000 = awhole ? 1000 : athou;
         o.ok = 1;
         o.red = chan[0] > 255 ? 8'd255 : chan[0][7:0];
         o.green = chan[1] > 255 ? 8'd255 : chan[1][7:0];
         o.blue = chan[2] > 255 ? 8'd255 : chan[2][7:0];
         o.alpha = 8'((a1000 * 255 + 500) / 1000);
      end
      colors_due.push_back(o);
      clear_parse();
   endtask

   // compare one accepted color with the oldest prediction
   always @(posedge clock) begin
      ccp_pkg::rsp_type want;
      if (reset) begin
         clear_parse();
         colors_due.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (colors_due.size() == 0) begin
               $error("unexpected color transaction %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = colors_due.pop_front();
               if (want != rsp_data) begin
                  if (want.ok != rsp_data.ok)
                     $error("ok: expected %0d actual %0d", want.ok, rsp_data.ok);
                  if (want.red != rsp_data.red)
                     $error("red: expected %0d actual %0d", want.red, rsp_data.red);
                  if (want.green != rsp_data.green)
                     $error("green: expected %0d actual %0d", want.green, rsp_data.green);
                  if (want.blue != rsp_data.blue)
                     $error("blue: expected %0d actual %0d", want.blue, rsp_data.blue);
                  if (want.alpha != rsp_data.alpha)
                     $error("alpha: expected %0d actual %0d", want.alpha, rsp_data.alpha);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_color(req_data);
         pending_count <= colors_due.size();
      end
   end
endmodule

/* tb/sv/tb_top.sv */
// Testbench top for css_color_token_parser: clock, reset, token stimulus with
// random idling and stalls, and the verdict. Depends on ccp_pkg and ccp_checker.
`timescale 1ns / 1ps
module tb_top;

   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   ccp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   ccp_pkg::rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_off = 0;

   css_color_token_parser uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   ccp_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // end the run at the cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // drive receiver stall at the falling edge; a long hold-off wins
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off <= hold_off - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // offer one character and wait for acceptance; valid stays up between
   // back-to-back characters and drops only while idling
   task automatic send_char(logic [7:0] c, logic l);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{char_code: c, last: l};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_token(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic string rand_hex(int n);
      string d = "0123456789abcdefABCDEF";
      string s = "";
      for (int i = 0; i < n; i++) s = {s, string'(d[$urandom_range(21)])};
      return s;
   endfunction

   function automatic string rand_num();
      int v;
      v = $urandom_range(3) == 0 ? $urandom_range(99999) : $urandom_range(300);
      return $sformatf("%0d", v);
   endfunction

   function automatic string rand_sep();
      string p = " ,\t\n";
      string s = "";
      int n;
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) s = {s, string'(p[$urandom_range(3)])};
      if (s.len() == 0) s = ",";
      return s;
   endfunction

   function automatic string rand_token();
      string names [30] = '{"transparent", "black", "white", "red", "green", "lime", "blue",
         "yellow", "cyan", "aqua", "magenta", "fuchsia", "gray", "grey", "silver",
         "maroon", "olive", "navy", "teal", "purple", "orange", "pink", "brown", "gold",
         "darkgray", "darkgrey", "lightgray", "lightgrey", "dodgerblue", "steelblue"};
      string s;
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: s = {"#", rand_hex($urandom_range(1) ? 3 : 6)};
         1: s = {"#", rand_hex($urandom_range(8))};
         2, 3: s = names[$urandom_range(29)];
         4: s = {"rgb(", rand_num(), rand_sep(), rand_num(), rand_sep(), rand_num(),
                 $urandom_range(1) ? ")" : ""};
         5, 6: s = {$urandom_range(1) ? "rgba(" : "RGBA(", rand_num(), rand_sep(),
                 rand_num(), rand_sep(), rand_num(), rand_sep(),
                 $urandom_range(1) ? {"0.", rand_num()} : rand_num(), ")"};
         7: begin
            s = names[$urandom_range(29)];
            s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255) | 1);
         end
         8: begin
            s = "";
            for (int i = 0; i <= $urandom_range(5); i++)
               s = {s, string'(8'($urandom_range(255) | 1))};
         end
         default: s = {"rgb(", rand_num(), $urandom_range(1) ? "x" : ",", ")"};
      endcase
      if ($urandom_range(4) == 0) s = {" \t", s};
      return s;
   endfunction

   // drop valid and pause until every color has come
   task automatic wait_drained();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      string directed [] = '{"#fff", "#000000", "#ABCDEF", "#12", "#1234", "#1234567",
         "#abc!x", "RGB(255,0,0)", "rgba(1 2 3 .5)", "rgba(300,256,99999,0.9995)",
         "rgba(1,2,3,1)", "rgba(1,2,3,.)", "rgb(1,2)", "rgb(,,)", "  \t\ntransparent",
         "TransParent", "Red", "steelblue", "reds", "", "   ", "rgba(1,2,3,0.0004)",
         "rgb(1 2 3"};
      string s;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed tokens; an empty token is a lone zero byte
      foreach (directed[i]) begin
         if (directed[i].len() == 0) send_char(8'd0, 1);
         else send_token(directed[i]);
      end
      send_char("#", 0); send_char("f", 0); send_char(8'd0, 0);
      send_char(8'hff, 1);
      send_char(8'hff, 1);
      wait_drained();

      // random phases: none, sender idle, receiver stall, both
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1 || p == 3) ? 73 : 0;
         recv_stall_pct = (p == 2 || p == 3) ? 73 : 0;
         if (p == 3) begin
            send_idle_pct = 8; recv_stall_pct = 8;
         end
         if (p == 2) hold_off <= 60;
         for (int t = 0; t < 15; t++) send_token(rand_token());
         // sender pause until every color has come
         wait_drained();
      end

      wait_drained();
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

/* files.f */
sv/ccp_pkg.sv
sv/ccp_name_match.sv
sv/css_color_token_parser.sv
tb/sv/ccp_checker.sv
tb/sv/tb_top.sv
